FILE: sv/bsf_pkg.sv
package bsf_pkg;

	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_FLAG       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ESC_FLAG   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ESC_ESCAPE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS    = 3'd4;

	localparam logic [7:0] RST_FLAG       = 8'h7e;
	localparam logic [7:0] RST_ESCAPE     = 8'h7d;
	localparam logic [7:0] RST_ESC_FLAG   = 8'h5e;
	localparam logic [7:0] RST_ESC_ESCAPE = 8'h5d;
	localparam logic [7:0] RST_ADDRESS    = 8'h03;

	localparam logic [7:0] CHECK_SEED = 8'hff;

	localparam logic [1:0] KIND_PLAIN  = 2'd0;
	localparam logic [1:0] KIND_ESCAPE = 2'd1;
	localparam logic [1:0] KIND_FLAG   = 2'd2;

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] escape_byte;
		logic [7:0] escaped_flag_code;
		logic [7:0] escaped_escape_code;
		logic [7:0] address_byte;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] data_kind;
		logic       first;
		logic       last;
		logic [7:0] ctrl;
		logic [7:0] check;
		logic [1:0] check_kind;
	} entry_t;

endpackage

FILE: sv/bsf_if.sv
interface byte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       first_byte;
	logic       last_byte;
	logic [7:0] control_field;

	modport source (output valid, output payload_byte, output first_byte,
		output last_byte, output control_field, input ready);
	modport sink (input valid, input payload_byte, input first_byte,
		input last_byte, input control_field, output ready);
endinterface

interface byte_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       run_end;
	logic       frame_end;

	modport source (output valid, output line_byte, output run_end,
		output frame_end, input ready);
	modport sink (input valid, input line_byte, input run_end,
		input frame_end, output ready);
endinterface

FILE: sv/bsf_front.sv
module bsf_front
	import bsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	byte_in_if.sink    payload,
	input  logic       q_full,
	output logic       push,
	output entry_t     push_entry
);

	logic [7:0] check_q;
	logic [7:0] check_new;

	function automatic logic [1:0] classify(input logic [7:0] b, input cfg_t c);
		logic [1:0] k;
		if (b == c.escape_byte)
			k = KIND_ESCAPE;
		else if (b == c.flag_byte)
			k = KIND_FLAG;
		else
			k = KIND_PLAIN;
		return k;
	endfunction

	assign payload.ready = !q_full;
	assign push          = payload.valid && !q_full;

	assign check_new = (payload.first_byte ? CHECK_SEED : check_q) ^ payload.payload_byte;

	always_comb begin
		push_entry.data       = payload.payload_byte;
		push_entry.data_kind  = classify(payload.payload_byte, cfg);
		push_entry.first      = payload.first_byte;
		push_entry.last       = payload.last_byte;
		push_entry.ctrl       = payload.control_field;
		push_entry.check      = check_new;
		push_entry.check_kind = classify(check_new, cfg);
	end

	// reseed after a closing request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q <= CHECK_SEED;
		end else if (push) begin
			check_q <= payload.last_byte ? CHECK_SEED : check_new;
		end
	end

endmodule

FILE: sv/bsf_queue.sv
module bsf_queue
	import bsf_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   nonempty,
	output entry_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/bsf_back.sv
module bsf_back
	import bsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  entry_t     head,
	input  logic       head_valid,
	output logic       pop,
	byte_out_if.source stream
);

	localparam logic [3:0] ST_START = 4'd0;
	localparam logic [3:0] ST_FLAG  = 4'd1;
	localparam logic [3:0] ST_ADDR  = 4'd2;
	localparam logic [3:0] ST_CTRL  = 4'd3;
	localparam logic [3:0] ST_BCC1  = 4'd4;
	localparam logic [3:0] ST_DATA  = 4'd5;
	localparam logic [3:0] ST_DATA2 = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_CHK2  = 4'd8;
	localparam logic [3:0] ST_CLOSE = 4'd9;

	logic [3:0] st_q;
	logic [3:0] phase;
	logic [3:0] nxt;
	logic [7:0] byte_d;
	logic       fend_d;
	logic       done;
	logic       advance;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_end_q;
	logic       frame_end_q;

	function automatic logic [7:0] code_of(input logic [1:0] k, input cfg_t c);
		return (k == KIND_ESCAPE) ? c.escaped_escape_code : c.escaped_flag_code;
	endfunction

	assign advance = head_valid && (!valid_q || stream.ready);
	assign pop     = advance && done;

	always_comb begin
		phase  = (st_q == ST_START) ? (head.first ? ST_FLAG : ST_DATA) : st_q;
		nxt    = ST_START;
		byte_d = cfg.flag_byte;
		fend_d = 1'b0;
		done   = 1'b0;
		case (phase)
			ST_FLAG: begin
				byte_d = cfg.flag_byte;
				nxt    = ST_ADDR;
			end
			ST_ADDR: begin
				byte_d = cfg.address_byte;
				nxt    = ST_CTRL;
			end
			ST_CTRL: begin
				byte_d = head.ctrl;
				nxt    = ST_BCC1;
			end
			ST_BCC1: begin
				byte_d = cfg.address_byte ^ head.ctrl;
				nxt    = ST_DATA;
			end
			ST_DATA: begin
				if (head.data_kind != KIND_PLAIN) begin
					byte_d = cfg.escape_byte;
					nxt    = ST_DATA2;
				end else begin
					byte_d = head.data;
					nxt    = ST_CHK;
					done   = !head.last;
				end
			end
			ST_DATA2: begin
				byte_d = code_of(head.data_kind, cfg);
				nxt    = ST_CHK;
				done   = !head.last;
			end
			ST_CHK: begin
				if (head.check_kind != KIND_PLAIN) begin
					byte_d = cfg.escape_byte;
					nxt    = ST_CHK2;
				end else begin
					byte_d = head.check;
					nxt    = ST_CLOSE;
				end
			end
			ST_CHK2: begin
				byte_d = code_of(head.check_kind, cfg);
				nxt    = ST_CLOSE;
			end
			ST_CLOSE: begin
				byte_d = cfg.flag_byte;
				fend_d = 1'b1;
				done   = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_START;
			valid_q <= 1'b0;
		end else if (advance) begin
			st_q    <= done ? ST_START : nxt;
			valid_q <= 1'b1;
		end else if (stream.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q      <= byte_d;
			run_end_q   <= done;
			frame_end_q <= fend_d;
		end
	end

	assign stream.valid     = valid_q;
	assign stream.line_byte = byte_q;
	assign stream.run_end   = run_end_q;
	assign stream.frame_end = frame_end_q;

endmodule

FILE: sv/byte_stuffing_framer.sv
// The first line byte of a request is held in the queue, then in the output register.
// Throughput: one line byte per cycle while a request is queued and the stream is
// ready; a request yields 1 to 9 line bytes (2 for an escaped payload byte).
// The front accepts a request every cycle while the queue has room.
// Reset: asynchronous, active low; queue emptied, check reseeded to 0xff,
// configuration registers return to their defaults.
module byte_stuffing_framer
	import bsf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	byte_in_if.sink                payload,
	byte_out_if.source             stream
);

	cfg_t   cfg_q;
	logic   q_full;
	logic   q_nonempty;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte           <= RST_FLAG;
			cfg_q.escape_byte         <= RST_ESCAPE;
			cfg_q.escaped_flag_code   <= RST_ESC_FLAG;
			cfg_q.escaped_escape_code <= RST_ESC_ESCAPE;
			cfg_q.address_byte        <= RST_ADDRESS;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FLAG:       cfg_q.flag_byte           <= cfg_data;
				REG_ESCAPE:     cfg_q.escape_byte         <= cfg_data;
				REG_ESC_FLAG:   cfg_q.escaped_flag_code   <= cfg_data;
				REG_ESC_ESCAPE: cfg_q.escaped_escape_code <= cfg_data;
				REG_ADDRESS:    cfg_q.address_byte        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.payload    (payload),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	bsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.nonempty   (q_nonempty),
		.head       (head)
	);

	bsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (q_nonempty),
		.pop        (pop),
		.stream     (stream)
	);

endmodule
